// File: src/wtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtd_pkg: shared types and constants of the WebSocket text deframer
// Frame header codes, queue entry layout and character length codes.
// ---------------------------------------------------------------------------
package wtd_pkg;

    localparam int LEN_BITS = 64;

    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] OPC_TEXT    = 4'h1;

    localparam logic [1:0] CLEN_NONE  = 2'd0;
    localparam logic [1:0] CLEN_TWO   = 2'd2;
    localparam logic [1:0] CLEN_THREE = 2'd3;

    // One payload beat handed from the parser to the UTF-8 filter
    typedef struct packed {
        logic [7:0] data;   // unmasked payload byte
        logic       text;   // byte belongs to a text frame
        logic       last;   // frame ends with this entry
    } t_q_entry;

    typedef struct packed {
        logic     vld;
        t_q_entry ent;
    } t_q_beat;

endpackage
`default_nettype wire

// File: src/wtd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtd_if: valid/ready channels of the deframer
// Received byte stream and extracted character stream.
// ---------------------------------------------------------------------------
interface wtd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wtd_char_if;
    logic       valid;
    logic       ready;
    logic [1:0] char_len;
    logic [7:0] char_byte0;
    logic [7:0] char_byte1;
    logic [7:0] char_byte2;
    logic       frame_end;
    modport source (output valid, output char_len, output char_byte0, output char_byte1,
                    output char_byte2, output frame_end, input ready);
    modport sink   (input valid, input char_len, input char_byte0, input char_byte1,
                    input char_byte2, input frame_end, output ready);
endinterface
`default_nettype wire

// File: src/websocket_text_deframer_utf8_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a byte that completes a character or a frame shows its beat after passing
//   through a queue entry and then the output register.
// Throughput: one byte per cycle; the parser stalls only when the two-entry queue is
//   full, which happens only while the output beat waits on o_char.ready.
// Reset: synchronous, active low; parser waits for a first header byte, queue and
//   output are empty, no partial UTF-8 sequence is held.
// ---------------------------------------------------------------------------
// websocket_text_deframer_utf8_filter: WebSocket deframer with UTF-8 filter
// Parses frame headers, unmasks payload and emits 2/3-byte UTF-8 characters
// of text frames plus a frame end marker.
// ---------------------------------------------------------------------------
module websocket_text_deframer_utf8_filter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wtd_byte_if.sink    i_rx,
    wtd_char_if.source  o_char
);
    import wtd_pkg::*;

    // Front: header walk (opcode, length, extended length, mask key) and
    // payload unmasking. Only text bytes and frame ends enter the queue;
    // non-text payload beats are swallowed here.
    t_q_beat push;
    t_q_beat head;
    logic    q_full;
    logic    pop;

    wtd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // Short queue so the parser keeps taking bytes while a result waits
    wtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Back: sequence assembly; held bytes are dropped at every frame end
    wtd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule
`default_nettype wire

// File: src/wtd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtd_front: frame header parser and payload unmasker
// Walks the header, unmasks payload beats, queues text bytes and frame ends.
// ---------------------------------------------------------------------------
module wtd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    wtd_byte_if.sink             i_rx,
    input  wire logic            i_q_full,
    output wtd_pkg::t_q_beat     o_push
);
    import wtd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [3:0]            r_ext_left, n_ext_left;
    logic                  r_is_text, n_is_text;
    logic                  r_masked, n_masked;
    logic [LEN_BITS-1:0]   r_pay_left, n_pay_left;
    logic [31:0]           r_key, n_key;
    logic [1:0]            r_mphase, n_mphase;

    logic                  accept;
    logic                  len_done;
    logic                  pay_start;
    logic [7:0]            key_byte;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;

    always_comb begin
        case (r_mphase)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_ext_left = r_ext_left;
        n_is_text  = r_is_text;
        n_masked   = r_masked;
        n_pay_left = r_pay_left;
        n_key      = r_key;
        n_mphase   = r_mphase;
        len_done   = 1'b0;
        pay_start  = 1'b0;
        o_push     = '0;

        if (accept) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked = i_rx.rx_byte[7];
                    n_mphase = 2'd0;
                    n_pay_left = '0;
                    if (i_rx.rx_byte[6:0] == LEN_EXT16) begin
                        n_ext_left = EXT16_BYTES;
                        n_phase    = PH_EXT;
                    end else if (i_rx.rx_byte[6:0] == LEN_EXT64) begin
                        n_ext_left = EXT64_BYTES;
                        n_phase    = PH_EXT;
                    end else begin
                        n_pay_left = LEN_BITS'(i_rx.rx_byte[6:0]);
                        len_done   = 1'b1;
                    end
                end
                PH_EXT: begin
                    // saturate once the next shift would overflow
                    if (r_pay_left[LEN_BITS-1 -: 8] != 8'd0) begin
                        n_pay_left = '1;
                    end else begin
                        n_pay_left = {r_pay_left[LEN_BITS-9:0], i_rx.rx_byte};
                    end
                    n_ext_left = r_ext_left - 4'd1;
                    len_done   = (n_ext_left == 4'd0);
                end
                PH_MASK: begin
                    n_key     = {r_key[23:0], i_rx.rx_byte};
                    n_mphase  = r_mphase + 2'd1;
                    pay_start = (n_mphase == 2'd0);
                end
                PH_PAYLOAD: begin
                    n_mphase   = r_mphase + 2'd1;
                    n_pay_left = r_pay_left - LEN_BITS'(1);
                    o_push.ent.data = r_masked ? (i_rx.rx_byte ^ key_byte) : i_rx.rx_byte;
                    o_push.ent.text = r_is_text;
                    o_push.ent.last = (n_pay_left == '0);
                    o_push.vld      = r_is_text || o_push.ent.last;
                    if (o_push.ent.last) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_is_text = (i_rx.rx_byte[3:0] == OPC_TEXT);
                    n_phase   = PH_HDR1;
                end
            endcase

            if (len_done) begin
                if (n_masked) begin
                    n_phase  = PH_MASK;
                    n_key    = '0;
                    n_mphase = 2'd0;
                end else begin
                    pay_start = 1'b1;
                end
            end

            if (pay_start) begin
                n_mphase = 2'd0;
                if (n_pay_left == '0) begin
                    // empty payload: frame ends on the last header byte
                    n_phase         = PH_HDR0;
                    o_push.vld      = 1'b1;
                    o_push.ent.last = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_ext_left <= 4'd0;
            r_is_text  <= 1'b0;
            r_masked   <= 1'b0;
            r_mphase   <= 2'd0;
        end else begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_is_text  <= n_is_text;
            r_masked   <= n_masked;
            r_mphase   <= n_mphase;
        end
        r_pay_left <= n_pay_left;
        r_key      <= n_key;
    end

endmodule
`default_nettype wire

// File: src/wtd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtd_fifo: two-entry queue between parser and UTF-8 filter
// Lets the parser and the filter stall independently.
// ---------------------------------------------------------------------------
module wtd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wtd_pkg::t_q_beat i_push,
    input  wire logic            i_pop,
    output logic                 o_full,
    output wtd_pkg::t_q_beat     o_head
);
    import wtd_pkg::*;

    t_q_entry   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_head.vld = (r_cnt != 2'd0);
    assign o_head.ent = r_mem[r_rp];
    assign do_push    = i_push.vld && !o_full;
    assign do_pop     = i_pop && o_head.vld;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> !o_full) else $error("push into full queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("queue pointers disagree");

endmodule
`default_nettype wire

// File: src/wtd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wtd_back: UTF-8 multibyte filter and output register
// Assembles 2- and 3-byte sequences, flags frame ends.
// ---------------------------------------------------------------------------
module wtd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wtd_pkg::t_q_beat i_head,
    output logic                 o_pop,
    wtd_char_if.source           o_char
);
    import wtd_pkg::*;

    logic [7:0] r_held0, r_held1, n_held0, n_held1;
    logic [1:0] r_hcnt, n_hcnt;
    logic [1:0] r_need, n_need;

    logic       r_out_valid;
    logic [1:0] r_len;
    logic [7:0] r_b0, r_b1, r_b2;
    logic       r_end;

    logic       can_load;
    logic       held_ok;
    logic       follower;
    logic [1:0] clen;
    logic [7:0] c0, c1, c2;
    logic       emit;
    logic [7:0] b;

    assign can_load = !r_out_valid || o_char.ready;
    assign o_pop    = i_head.vld && can_load;
    assign b        = i_head.ent.data;
    assign follower = (b inside {[8'h80:8'hBF]});
    assign held_ok  = (r_hcnt == 2'd1 && (r_need == 2'd1 || r_need == 2'd2)) ||
                      (r_hcnt == 2'd2 && r_need == 2'd1);

    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_hcnt  = r_hcnt;
        n_need  = r_need;
        clen    = CLEN_NONE;
        c0      = 8'd0;
        c1      = 8'd0;
        c2      = 8'd0;

        if (i_head.ent.text) begin
            if (held_ok && follower) begin
                if (r_hcnt == 2'd1 && r_need == 2'd1) begin
                    clen   = CLEN_TWO;
                    c0     = r_held0;
                    c1     = b;
                    n_hcnt = 2'd0;
                    n_need = 2'd0;
                end else if (r_hcnt == 2'd1) begin
                    n_held1 = b;
                    n_hcnt  = 2'd2;
                    n_need  = 2'd1;
                end else begin
                    clen   = CLEN_THREE;
                    c0     = r_held0;
                    c1     = r_held1;
                    c2     = b;
                    n_hcnt = 2'd0;
                    n_need = 2'd0;
                end
            end else begin
                // anything else drops the held bytes; the byte may start anew
                n_hcnt = 2'd0;
                n_need = 2'd0;
                if (b inside {[8'hC0:8'hDF]}) begin
                    n_held0 = b;
                    n_hcnt  = 2'd1;
                    n_need  = 2'd1;
                end else if (b inside {[8'hE0:8'hEF]}) begin
                    n_held0 = b;
                    n_hcnt  = 2'd1;
                    n_need  = 2'd2;
                end
            end
        end

        if (i_head.ent.last) begin
            n_hcnt = 2'd0;
            n_need = 2'd0;
        end

        emit = (clen != CLEN_NONE) || i_head.ent.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt      <= 2'd0;
            r_need      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hcnt <= n_hcnt;
                r_need <= n_need;
            end
            if (can_load) begin
                r_out_valid <= o_pop && emit;
            end
        end
        if (o_pop) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
        if (o_pop && emit) begin
            r_len <= clen;
            r_b0  <= c0;
            r_b1  <= c1;
            r_b2  <= c2;
            r_end <= i_head.ent.last;
        end
    end

    assign o_char.valid      = r_out_valid;
    assign o_char.char_len   = r_len;
    assign o_char.char_byte0 = r_b0;
    assign o_char.char_byte1 = r_b1;
    assign o_char.char_byte2 = r_b2;
    assign o_char.frame_end  = r_end;

    a_held_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt == 2'd2) |-> (r_need == 2'd1)) else $error("bad held state");
    a_held_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt == 2'd0) |-> (r_need == 2'd0)) else $error("need without held bytes");
    a_len_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_len != 2'd1)) else $error("one-byte character emitted");
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_len == CLEN_NONE) |-> r_end) else $error("empty result");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_char.ready) |-> !o_pop) else $error("pop while stalled");

endmodule
`default_nettype wire
